// ===== hdl/vector2d_alu_defines.svh =====
// Assertion macros used by the vector ALU top level.
`ifndef VECTOR2D_ALU_DEFINES_SVH
`define VECTOR2D_ALU_DEFINES_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define V2_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vector2d_alu: invariant violated");
// The consequent must hold in the same cycle as the antecedent.
`define V2_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector2d_alu: implication violated");
// The consequent must hold in the cycle after the antecedent.
`define V2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector2d_alu: next-cycle check violated");
`else
`define V2_ASSERT_ALWAYS(label, cond)
`define V2_ASSERT_IMPLY(label, ante, cons)
`define V2_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/v2alu_pkg.sv =====
// Types, constants and helper functions of the two-dimensional vector ALU.
package v2alu_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SUM_W       = 2 * COORD_WIDTH;
    localparam int ROOT_W      = COORD_WIDTH;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int PACK_W      = 2 * COORD_WIDTH;

    // Operation codes.
    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_SUB    = 3'd1;
    localparam logic [2:0] FUNC_SCALE  = 3'd2;
    localparam logic [2:0] FUNC_LENGTH = 3'd3;
    localparam logic [2:0] FUNC_NORM   = 3'd4;

    // Status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    localparam logic [PACK_W-1:0] SIGN_LIMIT = PACK_W'(1) << (COORD_WIDTH - 1);
    localparam logic [PACK_W-1:0] MAX_LIMIT  = SIGN_LIMIT - PACK_W'(1);

    typedef struct packed {
        logic [2:0]                    func;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] factor;
    } req_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] result_x;
        logic signed [COORD_WIDTH-1:0] result_y;
        logic [COORD_WIDTH-2:0]        magnitude;
        logic [1:0]                    status;
    } rsp_t;

    // Per-request data that travels alongside the root and divide stages.
    typedef struct packed {
        logic [2:0]             func;
        logic [COORD_WIDTH-1:0] rx;
        logic [COORD_WIDTH-1:0] ry;
        logic                   sat;
        logic                   neg_x;
        logic                   neg_y;
        logic [COORD_WIDTH-1:0] abs_x;
        logic [COORD_WIDTH-1:0] abs_y;
    } side_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] value;
        logic                   sat;
    } pack_t;

    // Apply a sign to a magnitude and saturate into the coordinate range.
    function automatic pack_t pack_signed(input logic neg, input logic [PACK_W-1:0] mag);
        logic [PACK_W-1:0] limit;
        logic [PACK_W-1:0] m;
        pack_t             r;
        limit   = neg ? SIGN_LIMIT : MAX_LIMIT;
        r.sat   = (mag > limit);
        m       = r.sat ? limit : mag;
        r.value = neg ? -m[COORD_WIDTH-1:0] : m[COORD_WIDTH-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/v2alu_front.sv =====
// Front stages: operand decode, add and subtract, the two multipliers and the scale result.
module v2alu_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  v2alu_pkg::req_t              req,
    output logic                         out_valid,
    output v2alu_pkg::side_t             side,
    output logic [v2alu_pkg::SUM_W-1:0]  sum
);

    localparam int W = v2alu_pkg::COORD_WIDTH;
    localparam int F = v2alu_pkg::FRAC_BITS;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    v2alu_pkg::side_t      s1_side_reg, s1_side_next;
    logic [W-1:0]          s1_abs_f_reg, s1_abs_f_next;
    logic                  s1_neg_f_reg, s1_neg_f_next;
    v2alu_pkg::side_t      s2_side_reg;
    logic                  s2_neg_f_reg;
    logic [2*W-1:0]        s2_prod_x_reg, s2_prod_x_next;
    logic [2*W-1:0]        s2_prod_y_reg, s2_prod_y_next;
    v2alu_pkg::side_t      s3_side_reg, s3_side_next;
    logic [2*W-1:0]        s3_sum_reg, s3_sum_next;

    logic [W:0]            sum_x, sum_y;
    logic                  sat_x, sat_y;
    logic [W-1:0]          mul_b_x, mul_b_y;
    v2alu_pkg::pack_t      scale_x, scale_y;

    // Stage one: absolute values and the saturating add or subtract.
    always_comb
    begin
        if (req.func == v2alu_pkg::FUNC_SUB)
        begin
            sum_x = {req.first_x[W-1], req.first_x} - {req.second_x[W-1], req.second_x};
            sum_y = {req.first_y[W-1], req.first_y} - {req.second_y[W-1], req.second_y};
        end
        else
        begin
            sum_x = {req.first_x[W-1], req.first_x} + {req.second_x[W-1], req.second_x};
            sum_y = {req.first_y[W-1], req.first_y} + {req.second_y[W-1], req.second_y};
        end
        sat_x = (sum_x[W] != sum_x[W-1]);
        sat_y = (sum_y[W] != sum_y[W-1]);

        s1_side_next.func  = req.func;
        s1_side_next.neg_x = req.first_x[W-1];
        s1_side_next.neg_y = req.first_y[W-1];
        s1_side_next.abs_x = req.first_x[W-1] ? (~req.first_x + 1'b1) : req.first_x;
        s1_side_next.abs_y = req.first_y[W-1] ? (~req.first_y + 1'b1) : req.first_y;
        s1_neg_f_next      = req.factor[W-1];
        s1_abs_f_next      = req.factor[W-1] ? (~req.factor + 1'b1) : req.factor;

        if (req.func == v2alu_pkg::FUNC_ADD || req.func == v2alu_pkg::FUNC_SUB)
        begin
            s1_side_next.rx  = sat_x ? {sum_x[W], {(W-1){~sum_x[W]}}} : sum_x[W-1:0];
            s1_side_next.ry  = sat_y ? {sum_y[W], {(W-1){~sum_y[W]}}} : sum_y[W-1:0];
            s1_side_next.sat = sat_x | sat_y;
        end
        else
        begin
            s1_side_next.rx  = '0;
            s1_side_next.ry  = '0;
            s1_side_next.sat = 1'b0;
        end
    end

    // Stage two: the multipliers serve the scale products or the squares.
    always_comb
    begin
        mul_b_x = (s1_side_reg.func == v2alu_pkg::FUNC_SCALE) ? s1_abs_f_reg : s1_side_reg.abs_x;
        mul_b_y = (s1_side_reg.func == v2alu_pkg::FUNC_SCALE) ? s1_abs_f_reg : s1_side_reg.abs_y;
        s2_prod_x_next = s1_side_reg.abs_x * mul_b_x;
        s2_prod_y_next = s1_side_reg.abs_y * mul_b_y;
    end

    // Stage three: scale result and the sum of squares.
    always_comb
    begin
        scale_x      = v2alu_pkg::pack_signed(s2_side_reg.neg_x ^ s2_neg_f_reg,
                                              s2_prod_x_reg >> F);
        scale_y      = v2alu_pkg::pack_signed(s2_side_reg.neg_y ^ s2_neg_f_reg,
                                              s2_prod_y_reg >> F);
        s3_side_next = s2_side_reg;
        if (s2_side_reg.func == v2alu_pkg::FUNC_SCALE)
        begin
            s3_side_next.rx  = scale_x.value;
            s3_side_next.ry  = scale_y.value;
            s3_side_next.sat = scale_x.sat | scale_y.sat;
        end
        s3_sum_next = s2_prod_x_reg + s2_prod_y_reg;
    end

    // Valid bits follow the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg   <= s1_side_next;
            s1_abs_f_reg  <= s1_abs_f_next;
            s1_neg_f_reg  <= s1_neg_f_next;
            s2_side_reg   <= s1_side_reg;
            s2_neg_f_reg  <= s1_neg_f_reg;
            s2_prod_x_reg <= s2_prod_x_next;
            s2_prod_y_reg <= s2_prod_y_next;
            s3_side_reg   <= s3_side_next;
            s3_sum_reg    <= s3_sum_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign side      = s3_side_reg;
    assign sum       = s3_sum_reg;

endmodule

// ===== hdl/v2alu_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module v2alu_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  v2alu_pkg::side_t              in_side,
    input  logic [v2alu_pkg::SUM_W-1:0]   radicand,
    output logic                          out_valid,
    output v2alu_pkg::side_t              out_side,
    output logic [v2alu_pkg::ROOT_W-1:0]  root
);

    localparam int W  = v2alu_pkg::ROOT_W;
    localparam int NW = v2alu_pkg::SUM_W;

    logic             vld_reg  [W];
    v2alu_pkg::side_t side_reg [W];
    logic [NW-1:0]    rad_reg  [W];
    logic [W+1:0]     rem_reg  [W];
    logic [W-1:0]     root_reg [W];

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        logic             vld_in;
        v2alu_pkg::side_t side_in;
        logic [NW-1:0]    rad_in;
        logic [W+1:0]     rem_in;
        logic [W-1:0]     root_in;
        logic [W+1:0]     rem_shift, trial;
        logic             ge;

        // Stage inputs come from the previous stage or the module input.
        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb
        begin
            rem_shift = {rem_in[W-1:0], rad_in[NW-1:NW-2]};
            trial     = {root_in, 2'b01};
            ge        = (rem_shift >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= ge ? (rem_shift - trial) : rem_shift;
                root_reg[k] <= {root_in[W-2:0], ge};
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign out_side  = side_reg[W-1];
    assign root      = root_reg[W-1];

endmodule

// ===== hdl/v2alu_div.sv =====
// Pipelined restoring divider for both normalize components, one quotient bit per stage.
module v2alu_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  v2alu_pkg::side_t              in_side,
    input  logic [v2alu_pkg::ROOT_W-1:0]  in_len,
    output logic                          out_valid,
    output v2alu_pkg::side_t              out_side,
    output logic [v2alu_pkg::ROOT_W-1:0]  out_len,
    output logic [v2alu_pkg::QUO_W-1:0]   quo_x,
    output logic [v2alu_pkg::QUO_W-1:0]   quo_y
);

    localparam int W = v2alu_pkg::ROOT_W;
    localparam int Q = v2alu_pkg::QUO_W;

    logic             vld_reg  [Q];
    v2alu_pkg::side_t side_reg [Q];
    logic [W-1:0]     len_reg  [Q];
    logic [W-1:0]     rem_x_reg[Q];
    logic [W-1:0]     rem_y_reg[Q];
    logic [Q-1:0]     q_x_reg  [Q];
    logic [Q-1:0]     q_y_reg  [Q];

    for (genvar k = 0; k < Q; k++)
    begin : g_stage
        logic             vld_in;
        v2alu_pkg::side_t side_in;
        logic [W-1:0]     len_in;
        logic [W-1:0]     rem_x_in, rem_y_in;
        logic [Q-1:0]     q_x_in, q_y_in;
        logic             bit_x, bit_y;
        logic [W:0]       try_x, try_y;
        logic             ge_x, ge_y;

        // The numerator is the component shifted up by the fraction bits; its
        // top part is below the length, so the quotient starts there.
        if (k == 0)
        begin : g_first
            assign vld_in   = in_valid;
            assign side_in  = in_side;
            assign len_in   = in_len;
            assign rem_x_in = in_side.abs_x >> 1;
            assign rem_y_in = in_side.abs_y >> 1;
            assign q_x_in   = '0;
            assign q_y_in   = '0;
            assign bit_x    = in_side.abs_x[0];
            assign bit_y    = in_side.abs_y[0];
        end
        else
        begin : g_next
            assign vld_in   = vld_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign len_in   = len_reg[k-1];
            assign rem_x_in = rem_x_reg[k-1];
            assign rem_y_in = rem_y_reg[k-1];
            assign q_x_in   = q_x_reg[k-1];
            assign q_y_in   = q_y_reg[k-1];
            assign bit_x    = 1'b0;
            assign bit_y    = 1'b0;
        end

        // Shift in one numerator bit and subtract the length where it fits.
        always_comb
        begin
            try_x = {rem_x_in, bit_x};
            try_y = {rem_y_in, bit_y};
            ge_x  = (try_x >= {1'b0, len_in});
            ge_y  = (try_y >= {1'b0, len_in});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k]  <= side_in;
                len_reg[k]   <= len_in;
                rem_x_reg[k] <= ge_x ? W'(try_x - {1'b0, len_in}) : try_x[W-1:0];
                rem_y_reg[k] <= ge_y ? W'(try_y - {1'b0, len_in}) : try_y[W-1:0];
                q_x_reg[k]   <= {q_x_in[Q-2:0], ge_x};
                q_y_reg[k]   <= {q_y_in[Q-2:0], ge_y};
            end
        end
    end

    assign out_valid = vld_reg[Q-1];
    assign out_side  = side_reg[Q-1];
    assign out_len   = len_reg[Q-1];
    assign quo_x     = q_x_reg[Q-1];
    assign quo_y     = q_y_reg[Q-1];

endmodule

// ===== hdl/vector2d_alu.sv =====
// Top level of the two-dimensional vector ALU: pipeline, result packing and output skid.
//
//   channel  payload  handshake              direction
//   req      req_t    req_valid / req_stall  request into the block
//   rsp      rsp_t    rsp_valid / rsp_stall  response out of the block
//
// One request is taken every cycle while req_stall is low; each response passes through
// three front stages with the multipliers, one stage per root bit, one per quotient bit
// and the output register.
// Reset clears only the valid bits; payload registers carry no reset.
// A one-entry skid buffer behind the output register absorbs rsp_stall; req_stall is
// high, straight from a register, only while that buffer holds a response.
`include "vector2d_alu_defines.svh"

module vector2d_alu (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  v2alu_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output v2alu_pkg::rsp_t  rsp
);

    localparam int W = v2alu_pkg::COORD_WIDTH;

    logic                          en;
    logic                          front_valid, sqrt_valid, div_valid;
    v2alu_pkg::side_t              front_side, sqrt_side, div_side;
    logic [v2alu_pkg::SUM_W-1:0]   front_sum;
    logic [v2alu_pkg::ROOT_W-1:0]  sqrt_root, div_len;
    logic [v2alu_pkg::QUO_W-1:0]   quo_x, quo_y;
    v2alu_pkg::pack_t              norm_x, norm_y;
    v2alu_pkg::rsp_t               fin;
    logic                          fin_sat;

    logic                          rsp_valid_reg, skid_full_reg;
    v2alu_pkg::rsp_t               rsp_reg, skid_reg;
    logic                          pop, push;

    assign en = !skid_full_reg;

    v2alu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .req       (req),
        .out_valid (front_valid),
        .side      (front_side),
        .sum       (front_sum)
    );

    v2alu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .radicand  (front_sum),
        .out_valid (sqrt_valid),
        .out_side  (sqrt_side),
        .root      (sqrt_root)
    );

    v2alu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_side   (sqrt_side),
        .in_len    (sqrt_root),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_len   (div_len),
        .quo_x     (quo_x),
        .quo_y     (quo_y)
    );

    // Final packing of the response per operation.
    always_comb
    begin
        norm_x = v2alu_pkg::pack_signed(div_side.neg_x, v2alu_pkg::PACK_W'(quo_x));
        norm_y = v2alu_pkg::pack_signed(div_side.neg_y, v2alu_pkg::PACK_W'(quo_y));
        fin     = '0;
        fin_sat = 1'b0;
        unique case (div_side.func) inside
            v2alu_pkg::FUNC_ADD, v2alu_pkg::FUNC_SUB, v2alu_pkg::FUNC_SCALE:
            begin
                fin.result_x = div_side.rx;
                fin.result_y = div_side.ry;
                fin_sat      = div_side.sat;
            end
            v2alu_pkg::FUNC_LENGTH:
            begin
                fin_sat       = div_len[W-1];
                fin.magnitude = div_len[W-1] ? {(W-1){1'b1}} : div_len[W-2:0];
            end
            v2alu_pkg::FUNC_NORM:
            begin
                if (div_len == '0)
                begin
                    fin.status = v2alu_pkg::STATUS_ZERO;
                end
                else
                begin
                    fin.result_x = norm_x.value;
                    fin.result_y = norm_y.value;
                    fin_sat      = norm_x.sat | norm_y.sat;
                end
            end
            default:
            begin
                fin_sat = 1'b0;
            end
        endcase
        if (fin_sat && fin.status == v2alu_pkg::STATUS_OK)
        begin
            fin.status = v2alu_pkg::STATUS_SAT;
        end
    end

    // Output register with one skid entry behind it.
    assign pop  = rsp_valid_reg && !rsp_stall;
    assign push = en && div_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (pop)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!rsp_valid_reg || pop)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (pop)
            begin
                rsp_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!rsp_valid_reg || pop)
            begin
                rsp_reg <= fin;
            end
            else
            begin
                skid_reg <= fin;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign req_stall = skid_full_reg;

    // Checks on the output buffering and on response contents.
    `V2_ASSERT_IMPLY(a_skid_behind_output, skid_full_reg, rsp_valid_reg)
    `V2_ASSERT_NEXT(a_skid_holds_on_stall, skid_full_reg && rsp_stall, skid_full_reg)
    `V2_ASSERT_IMPLY(a_zero_vector_clean,
        rsp_valid_reg && rsp_reg.status == v2alu_pkg::STATUS_ZERO,
        rsp_reg.result_x == '0 && rsp_reg.result_y == '0 && rsp_reg.magnitude == '0)
    `V2_ASSERT_IMPLY(a_length_no_vector,
        rsp_valid_reg && rsp_reg.magnitude != '0,
        rsp_reg.result_x == '0 && rsp_reg.result_y == '0)

endmodule

// ===== dv/tb_vector2d_alu.sv =====
// Self-checking testbench of the two-dimensional vector ALU.
`timescale 1ns / 1ps

module tb_vector2d_alu;

    localparam int LATENCY   = v2alu_pkg::COORD_WIDTH + v2alu_pkg::FRAC_BITS + 5;
    localparam int CYCLE_CAP = 400000;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    v2alu_pkg::req_t  req;
    logic             rsp_valid;
    logic             rsp_stall;
    v2alu_pkg::rsp_t  rsp;

    v2alu_pkg::req_t  pending_reqs[$];
    v2alu_pkg::rsp_t  expected_rsps[$];
    int    req_gap;
    int    rsp_gap;
    int    errors;
    int    cycles;
    bit    stim_done;
    bit    hold_off;

    vector2d_alu i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clip a signed magnitude into the coordinate range and flag saturation.
    function automatic logic [31:0] clip(input logic neg, input logic [127:0] mag,
                                         inout logic sat);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag > lim)
        begin
            mag = lim;
            sat = 1'b1;
        end
        return neg ? -mag[31:0] : mag[31:0];
    endfunction

    // Floor square root of a 64-bit sum of squares.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 32; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    // Compute the response that a request should produce.
    function automatic v2alu_pkg::rsp_t vector_result(input v2alu_pkg::req_t r);
        v2alu_pkg::rsp_t o;
        logic         sat;
        logic signed [33:0] sx;
        logic signed [33:0] sy;
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] fm;
        logic [127:0] len;
        o   = '0;
        sat = 1'b0;
        ax  = r.first_x[31] ? 128'(-64'(r.first_x)) : 128'(r.first_x);
        ay  = r.first_y[31] ? 128'(-64'(r.first_y)) : 128'(r.first_y);
        fm  = r.factor[31] ? 128'(-64'(r.factor)) : 128'(r.factor);
        case (r.func) inside
            v2alu_pkg::FUNC_ADD, v2alu_pkg::FUNC_SUB:
            begin
                if (r.func == v2alu_pkg::FUNC_ADD)
                begin
                    sx = 34'(r.first_x) + 34'(r.second_x);
                    sy = 34'(r.first_y) + 34'(r.second_y);
                end
                else
                begin
                    sx = 34'(r.first_x) - 34'(r.second_x);
                    sy = 34'(r.first_y) - 34'(r.second_y);
                end
                o.result_x = clip(sx < 0, 128'(sx < 0 ? -sx : sx), sat);
                o.result_y = clip(sy < 0, 128'(sy < 0 ? -sy : sy), sat);
            end
            v2alu_pkg::FUNC_SCALE:
            begin
                o.result_x = clip(r.first_x[31] != r.factor[31],
                                  (ax * fm) >> v2alu_pkg::FRAC_BITS, sat);
                o.result_y = clip(r.first_y[31] != r.factor[31],
                                  (ay * fm) >> v2alu_pkg::FRAC_BITS, sat);
            end
            v2alu_pkg::FUNC_LENGTH, v2alu_pkg::FUNC_NORM:
            begin
                len = 128'(floor_sqrt(ax * ax + ay * ay));
                if (r.func == v2alu_pkg::FUNC_LENGTH)
                begin
                    if (len > 128'h7FFF_FFFF)
                    begin
                        len = 128'h7FFF_FFFF;
                        sat = 1'b1;
                    end
                    o.magnitude = len[30:0];
                end
                else if (len == 0)
                    o.status = v2alu_pkg::STATUS_ZERO;
                else
                begin
                    o.result_x = clip(r.first_x[31],
                                      (ax << v2alu_pkg::FRAC_BITS) / len, sat);
                    o.result_y = clip(r.first_y[31],
                                      (ay << v2alu_pkg::FRAC_BITS) / len, sat);
                end
            end
            default: ;
        endcase
        if (sat && o.status == v2alu_pkg::STATUS_OK)
            o.status = v2alu_pkg::STATUS_SAT;
        return o;
    endfunction

    // Random coordinate that favors the edges of the range.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            4: return 32'($urandom_range(0, 32'hFF_FFFF)) - 32'h80_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic v2alu_pkg::req_t random_req();
        v2alu_pkg::req_t r;
        r.func     = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
        r.first_x  = pick_coord();
        r.first_y  = pick_coord();
        r.second_x = pick_coord();
        r.second_y = pick_coord();
        r.factor   = pick_coord();
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
                                            : (($urandom_range(0, 2) == 0) ?
                                               $urandom_range(1, 3) : 0);
    endfunction

    function automatic v2alu_pkg::req_t make_req(input logic [2:0] f, input logic [31:0] a,
                                                 input logic [31:0] b, input logic [31:0] c,
                                                 input logic [31:0] d, input logic [31:0] e);
        v2alu_pkg::req_t r;
        r = '{func: f, first_x: a, first_y: b, second_x: c, second_y: d, factor: e};
        return r;
    endfunction

    // Fill the request queue: directed corners first, then random requests.
    initial
    begin
        logic [31:0] mn;
        logic [31:0] mx;
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_ADD, mx, mn, mx, mn, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_ADD, 32'h1_0000, -32'sd5,
                                        32'h2_0000, 7, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_SUB, mn, mx, 1, -32'sd1, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_SUB, mx, mn, mx, mn, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_SCALE, mx, mn, 0, 0, mn));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_SCALE, mn, mx, 0, 0, mx));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_SCALE, 32'h3_0000, -32'sh2_8000,
                                        0, 0, -32'sh1_8000));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_SCALE, -32'sd3, 5, 0, 0, 32'h8000));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_LENGTH, mn, mn, 0, 0, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_LENGTH, mx, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_LENGTH, 32'h3_0000, 32'h4_0000,
                                        0, 0, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_LENGTH, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_NORM, 0, 0, mx, mn, mx));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_NORM, mn, mn, 0, 0, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_NORM, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_NORM, -32'sh3_0000, 32'h4_0000,
                                        0, 0, 0));
        pending_reqs.push_back(make_req(v2alu_pkg::FUNC_NORM, 0, mn, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd5, mx, mn, mx, mn, mx));
        pending_reqs.push_back(make_req(3'd7, mn, mx, mn, mx, mn));
        repeat (700)
            pending_reqs.push_back(random_req());
    end

    // Reset once, then wait for the queue to drain and all responses to return.
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_rsps.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Request driver: random gaps and one full drain partway through.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= 0;
            stim_done <= 1'b0;
            hold_off  <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsps.push_back(vector_result(req));
            if (!req_valid || !req_stall)
            begin
                if (hold_off && expected_rsps.size() == 0 &&
                    !(req_valid && !req_stall))
                    hold_off <= 1'b0;
                if (req_gap > 0 || hold_off || pending_reqs.size() == 0)
                begin
                    req_valid <= 1'b0;
                    if (req_gap > 0)
                        req_gap <= req_gap - 1;
                    if (pending_reqs.size() == 0)
                        stim_done <= 1'b1;
                end
                else
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_gap   <= pick_gap();
                    if (pending_reqs.size() == 350)
                        hold_off <= 1'b1;
                end
            end
        end
    end

    // Response monitor: random stalls and comparison of each whole response.
    always @(posedge clk or negedge rst_n)
    begin
        v2alu_pkg::rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_gap   <= 0;
            errors    <= 0;
            cycles    <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_CAP)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                if (rsp_valid && !rsp_stall)
                begin
                    if (expected_rsps.size() == 0)
                    begin
                        $display("%t unexpected response %p", $realtime, rsp);
                        errors <= errors + 1;
                    end
                    else
                    begin
                        want = expected_rsps.pop_front();
                        if (want !== rsp)
                        begin
                            $display("%t mismatch: expected %p actual %p",
                                     $realtime, want, rsp);
                            errors <= errors + 1;
                        end
                    end
                end
                if (rsp_gap > 0)
                begin
                    rsp_stall <= 1'b1;
                    rsp_gap   <= rsp_gap - 1;
                end
                else
                begin
                    rsp_stall <= 1'b0;
                    rsp_gap   <= pick_gap();
                end
            end
        end
    end

endmodule
